// ===== rtl/lsrc_pkg.sv =====
// Shared constants, types and command/status structs of the line segment clipper.
package lsrc_pkg;

  localparam int COORD_BITS       = 16;
  localparam int MAX_SUBDIVISIONS = 8;
  localparam int PROD_BITS        = 2 * COORD_BITS;
  localparam int REM_BITS         = COORD_BITS + 1;
  localparam int SUB_CNT_BITS     = $clog2(MAX_SUBDIVISIONS + 1);
  localparam int DIV_CNT_BITS     = $clog2(PROD_BITS);
  localparam int NUM_REGS         = 4;
  localparam int REG_IDX_BITS     = $clog2(NUM_REGS);

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [COORD_BITS:0]   diff_t;
  typedef logic [COORD_BITS-1:0]        mag_t;
  typedef logic [3:0]                   outcode_t;
  typedef logic [REG_IDX_BITS-1:0]      reg_idx_t;

  localparam outcode_t CODE_ABOVE = 4'h8;
  localparam outcode_t CODE_BELOW = 4'h4;
  localparam outcode_t CODE_RIGHT = 4'h2;
  localparam outcode_t CODE_LEFT  = 4'h1;

  localparam reg_idx_t REG_LEFT   = 2'd0;
  localparam reg_idx_t REG_TOP    = 2'd1;
  localparam reg_idx_t REG_RIGHT  = 2'd2;
  localparam reg_idx_t REG_BOTTOM = 2'd3;

  localparam coord_t RESET_LEFT   = coord_t'(0);
  localparam coord_t RESET_TOP    = coord_t'(0);
  localparam coord_t RESET_RIGHT  = coord_t'(639);
  localparam coord_t RESET_BOTTOM = coord_t'(479);

  typedef struct packed {
    logic load;
    logic setup;
    logic mult;
    logic div_step;
    logic update;
    logic capture;
    logic cap_visible;
  } lsrc_cmd_t;

  typedef struct packed {
    logic both_inside;
    logic share_bit;
  } lsrc_status_t;

endpackage

// ===== rtl/lsrc_if.sv =====
// Valid/ready channels carrying segments in and clipped results out.
interface lsrc_seg_if;
  import lsrc_pkg::*;
  logic   valid;
  logic   ready;
  coord_t start_x;
  coord_t start_y;
  coord_t end_x;
  coord_t end_y;
  modport source (output valid, start_x, start_y, end_x, end_y, input ready);
  modport sink (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

interface lsrc_res_if;
  import lsrc_pkg::*;
  logic   valid;
  logic   ready;
  logic   visible;
  coord_t clipped_start_x;
  coord_t clipped_start_y;
  coord_t clipped_end_x;
  coord_t clipped_end_y;
  modport source (output valid, visible, clipped_start_x, clipped_start_y,
                  clipped_end_x, clipped_end_y, input ready);
  modport sink (input valid, visible, clipped_start_x, clipped_start_y,
                clipped_end_x, clipped_end_y, output ready);
endinterface

// ===== rtl/lsrc_datapath.sv =====
// Clip rectangle, endpoint registers, multiplier, serial divider and result register.
module lsrc_datapath (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_write,
  input  lsrc_pkg::reg_idx_t      cfg_index,
  input  lsrc_pkg::coord_t        cfg_data,
  input  lsrc_pkg::coord_t        in_start_x,
  input  lsrc_pkg::coord_t        in_start_y,
  input  lsrc_pkg::coord_t        in_end_x,
  input  lsrc_pkg::coord_t        in_end_y,
  input  lsrc_pkg::lsrc_cmd_t     cmd,
  output lsrc_pkg::lsrc_status_t  status,
  output logic                    res_visible,
  output lsrc_pkg::coord_t        res_start_x,
  output lsrc_pkg::coord_t        res_start_y,
  output lsrc_pkg::coord_t        res_end_x,
  output lsrc_pkg::coord_t        res_end_y
);
  import lsrc_pkg::*;

  coord_t clip_left, clip_top, clip_right, clip_bottom;
  coord_t px0, py0, px1, py1;
  mag_t   am, bm, dm;
  logic   neg, moved_sel, sel_y;
  coord_t edge_val;
  logic [PROD_BITS-1:0] prod;
  logic [REM_BITS-1:0]  rem;

  outcode_t c0, c1, code;
  coord_t   tx, ty, ox, oy;
  diff_t    a_d, b_d, d_d;
  coord_t   edge_sel;
  logic     sel_y_sel;

  logic [REM_BITS-1:0] rem_sh;
  logic                q_bit;
  diff_t               q_val, offset;
  coord_t              new_coord;

  function automatic outcode_t outcode(coord_t x, coord_t y, coord_t l, coord_t t,
                                       coord_t r, coord_t b);
    outcode_t c;
    c = '0;
    if (x < l) c = c | CODE_LEFT;
    if (x > r) c = c | CODE_RIGHT;
    if (y < t) c = c | CODE_ABOVE;
    if (y > b) c = c | CODE_BELOW;
    return c;
  endfunction

  function automatic diff_t sub(coord_t x, coord_t y);
    return diff_t'(x) - diff_t'(y);
  endfunction

  function automatic mag_t mag(diff_t v);
    diff_t m;
    m = v[COORD_BITS] ? -v : v;
    return m[COORD_BITS-1:0];
  endfunction

  assign c0 = outcode(px0, py0, clip_left, clip_top, clip_right, clip_bottom);
  assign c1 = outcode(px1, py1, clip_left, clip_top, clip_right, clip_bottom);
  assign status.both_inside = (c0 == '0) && (c1 == '0);
  assign status.share_bit   = (c0 & c1) != '0;

  // The first endpoint moves if it lies outside, otherwise the second.
  always_comb begin
    code = (c0 != '0) ? c0 : c1;
    tx = (c0 != '0) ? px0 : px1;
    ty = (c0 != '0) ? py0 : py1;
    ox = (c0 != '0) ? px1 : px0;
    oy = (c0 != '0) ? py1 : py0;
    priority if ((code & CODE_ABOVE) != '0) begin
      sel_y_sel = 1'b1;
      edge_sel  = clip_top;
    end else if ((code & CODE_BELOW) != '0) begin
      sel_y_sel = 1'b1;
      edge_sel  = clip_bottom;
    end else if ((code & CODE_RIGHT) != '0) begin
      sel_y_sel = 1'b0;
      edge_sel  = clip_right;
    end else begin
      sel_y_sel = 1'b0;
      edge_sel  = clip_left;
    end
    if (sel_y_sel) begin
      a_d = sub(ox, tx);
      b_d = sub(edge_sel, ty);
      d_d = sub(oy, ty);
    end else begin
      a_d = sub(oy, ty);
      b_d = sub(edge_sel, tx);
      d_d = sub(ox, tx);
    end
  end

  always_comb begin
    rem_sh = {rem[REM_BITS-2:0], prod[PROD_BITS-1]};
    q_bit  = rem_sh >= REM_BITS'(dm);
    q_val  = diff_t'(prod[COORD_BITS:0]);
    if (dm == '0) offset = '0;
    else offset = neg ? -q_val : q_val;
    if (sel_y) new_coord = coord_t'((moved_sel ? diff_t'(px1) : diff_t'(px0)) + offset);
    else new_coord = coord_t'((moved_sel ? diff_t'(py1) : diff_t'(py0)) + offset);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clip_left   <= RESET_LEFT;
      clip_top    <= RESET_TOP;
      clip_right  <= RESET_RIGHT;
      clip_bottom <= RESET_BOTTOM;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_LEFT:   clip_left   <= cfg_data;
        REG_TOP:    clip_top    <= cfg_data;
        REG_RIGHT:  clip_right  <= cfg_data;
        REG_BOTTOM: clip_bottom <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      px0 <= in_start_x;
      py0 <= in_start_y;
      px1 <= in_end_x;
      py1 <= in_end_y;
    end
    if (cmd.setup) begin
      am        <= mag(a_d);
      bm        <= mag(b_d);
      dm        <= mag(d_d);
      neg       <= a_d[COORD_BITS] ^ b_d[COORD_BITS] ^ d_d[COORD_BITS];
      moved_sel <= (c0 == '0);
      sel_y     <= sel_y_sel;
      edge_val  <= edge_sel;
    end
    if (cmd.mult) begin
      prod <= PROD_BITS'(am) * PROD_BITS'(bm);
      rem  <= '0;
    end
    // Restoring division: the product shifts out at the top, quotient bits in below.
    if (cmd.div_step) begin
      rem  <= q_bit ? rem_sh - REM_BITS'(dm) : rem_sh;
      prod <= {prod[PROD_BITS-2:0], q_bit};
    end
    if (cmd.update) begin
      if (sel_y) begin
        if (moved_sel) begin
          px1 <= new_coord;
          py1 <= edge_val;
        end else begin
          px0 <= new_coord;
          py0 <= edge_val;
        end
      end else begin
        if (moved_sel) begin
          py1 <= new_coord;
          px1 <= edge_val;
        end else begin
          py0 <= new_coord;
          px0 <= edge_val;
        end
      end
    end
    if (cmd.capture) begin
      res_visible <= cmd.cap_visible;
      res_start_x <= cmd.cap_visible ? px0 : '0;
      res_start_y <= cmd.cap_visible ? py0 : '0;
      res_end_x   <= cmd.cap_visible ? px1 : '0;
      res_end_y   <= cmd.cap_visible ? py1 : '0;
    end
  end

endmodule

// ===== rtl/lsrc_controller.sv =====
// State machine that sequences outcode tests, subdivisions and result hand-off.
module lsrc_controller (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  input  lsrc_pkg::lsrc_status_t status,
  output lsrc_pkg::lsrc_cmd_t    cmd
);
  import lsrc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_CHECK, S_SETUP, S_MULT, S_DIVIDE, S_UPDATE, S_DONE
  } state_t;

  state_t                  state;
  logic [SUB_CNT_BITS-1:0] subs;
  logic [DIV_CNT_BITS-1:0] div_cnt;
  logic                    done_vis;
  logic                    out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd             = '0;
    cmd.load        = (state == S_IDLE) && in_valid;
    cmd.setup       = (state == S_SETUP);
    cmd.mult        = (state == S_MULT);
    cmd.div_step    = (state == S_DIVIDE);
    cmd.update      = (state == S_UPDATE);
    cmd.capture     = (state == S_DONE) && out_free;
    cmd.cap_visible = done_vis;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      subs      <= '0;
      div_cnt   <= '0;
      done_vis  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if ((state == S_DONE) && out_free) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            subs  <= '0;
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (status.both_inside) begin
            done_vis <= 1'b1;
            state    <= S_DONE;
          end else if (status.share_bit || subs == SUB_CNT_BITS'(MAX_SUBDIVISIONS)) begin
            done_vis <= 1'b0;
            state    <= S_DONE;
          end else begin
            subs  <= subs + 1'b1;
            state <= S_SETUP;
          end
        end
        S_SETUP: state <= S_MULT;
        S_MULT: begin
          div_cnt <= '0;
          state   <= S_DIVIDE;
        end
        S_DIVIDE: begin
          div_cnt <= div_cnt + 1'b1;
          if (div_cnt == DIV_CNT_BITS'(PROD_BITS - 1)) state <= S_UPDATE;
        end
        S_UPDATE: state <= S_CHECK;
        S_DONE: begin
          if (out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/line_segment_rect_clipper_unit.sv =====
// Cohen-Sutherland clipper: one segment at a time against the configured rectangle.
// The number of subdivisions N per segment ranges from 0 to 8.
// Each subdivision costs the outcode test, setup, one multiply, 32 divider steps and the update.
// A new segment is taken only after the last result has gone to the output register, where results wait.
// Reset restores the rectangle to left 0, top 0, right 639, bottom 479 and empties the block.
module line_segment_rect_clipper_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  lsrc_pkg::reg_idx_t cfg_index,
  input  lsrc_pkg::coord_t   cfg_data,
  lsrc_seg_if.sink           seg_in,
  lsrc_res_if.source         res_out
);
  import lsrc_pkg::*;

  lsrc_cmd_t    cmd;
  lsrc_status_t status;

  lsrc_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (seg_in.valid),
    .in_ready  (seg_in.ready),
    .out_valid (res_out.valid),
    .out_ready (res_out.ready),
    .status    (status),
    .cmd       (cmd)
  );

  lsrc_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_start_x  (seg_in.start_x),
    .in_start_y  (seg_in.start_y),
    .in_end_x    (seg_in.end_x),
    .in_end_y    (seg_in.end_y),
    .cmd         (cmd),
    .status      (status),
    .res_visible (res_out.visible),
    .res_start_x (res_out.clipped_start_x),
    .res_start_y (res_out.clipped_start_y),
    .res_end_x   (res_out.clipped_end_x),
    .res_end_y   (res_out.clipped_end_y)
  );

`ifndef SYNTHESIS
  // A rejected segment always reports all-zero coordinates.
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    res_out.valid && !res_out.visible |->
      res_out.clipped_start_x == '0 && res_out.clipped_start_y == '0 &&
      res_out.clipped_end_x == '0 && res_out.clipped_end_y == '0)
    else $error("rejected result carries nonzero coordinates");

  // Once a segment is taken, the block is busy for at least the outcode test.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    seg_in.valid && seg_in.ready |=> !seg_in.ready)
    else $error("input accepted twice in a row");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res_out.valid)
    else $error("result valid right after reset");
`endif

endmodule

// ===== test/tb_line_segment_rect_clipper_unit.sv =====
// Testbench for the Cohen-Sutherland line segment clipper: directed table plus random segments.
module tb_line_segment_rect_clipper_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import lsrc_pkg::*;

  typedef struct packed {
    logic   visible;
    coord_t sx;
    coord_t sy;
    coord_t ex;
    coord_t ey;
  } clip_result_t;

  typedef struct {
    coord_t sx;
    coord_t sy;
    coord_t ex;
    coord_t ey;
    logic   known;
    clip_result_t res;
  } seg_row_t;

  logic clk;
  logic rst;
  logic cfg_write;
  reg_idx_t cfg_index;
  coord_t cfg_data;

  lsrc_seg_if seg_ch ();
  lsrc_res_if res_ch ();

  line_segment_rect_clipper_unit uut (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .seg_in(seg_ch.sink), .res_out(res_ch.source)
  );

  // Current rectangle as the testbench believes it to be.
  longint win_l, win_t, win_r, win_b;
  clip_result_t pending_clips[$];
  int failures;
  int send_idle_pct;
  int recv_idle_pct;
  bit recv_hold;
  int recv_hold_cycles;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic int region_code(longint x, longint y);
    int c;
    c = 0;
    if (x < win_l) c |= CODE_LEFT;
    if (x > win_r) c |= CODE_RIGHT;
    if (y < win_t) c |= CODE_ABOVE;
    if (y > win_b) c |= CODE_BELOW;
    return c;
  endfunction

  function automatic longint scaled_offset(longint a, longint b, longint d);
    longint p;
    if (d == 0) return 0;
    p = a * b;
    // SystemVerilog division of signed integers truncates toward zero.
    return p / d;
  endfunction

  function automatic clip_result_t clip_segment(coord_t sx, coord_t sy, coord_t ex,
                                                coord_t ey);
    longint px[2];
    longint py[2];
    int subs;
    int c0, c1, c, m, o;
    clip_result_t r;
    px[0] = sx; py[0] = sy; px[1] = ex; py[1] = ey;
    subs = 0;
    r = '{1'b0, '0, '0, '0, '0};
    forever begin
      c0 = region_code(px[0], py[0]);
      c1 = region_code(px[1], py[1]);
      if (c0 == 0 && c1 == 0) begin
        r.visible = 1'b1;
        r.sx = coord_t'(px[0]); r.sy = coord_t'(py[0]);
        r.ex = coord_t'(px[1]); r.ey = coord_t'(py[1]);
        break;
      end
      if ((c0 & c1) != 0 || subs >= MAX_SUBDIVISIONS) break;
      subs++;
      m = (c0 != 0) ? 0 : 1;
      o = 1 - m;
      c = (m == 0) ? c0 : c1;
      if (c & CODE_ABOVE) begin
        px[m] += scaled_offset(px[o] - px[m], win_t - py[m], py[o] - py[m]);
        py[m] = win_t;
      end else if (c & CODE_BELOW) begin
        px[m] += scaled_offset(px[o] - px[m], win_b - py[m], py[o] - py[m]);
        py[m] = win_b;
      end else if (c & CODE_RIGHT) begin
        py[m] += scaled_offset(py[o] - py[m], win_r - px[m], px[o] - px[m]);
        px[m] = win_r;
      end else begin
        py[m] += scaled_offset(py[o] - py[m], win_l - px[m], px[o] - px[m]);
        px[m] = win_l;
      end
    end
    return r;
  endfunction

  task automatic write_reg(reg_idx_t idx, coord_t val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      REG_LEFT: win_l = val;
      REG_TOP: win_t = val;
      REG_RIGHT: win_r = val;
      REG_BOTTOM: win_b = val;
    endcase
  endtask

  // Writes follow each other without a gap; the enable drops after the last one.
  task automatic set_window(coord_t l, coord_t t, coord_t r, coord_t b);
    write_reg(REG_LEFT, l);
    write_reg(REG_TOP, t);
    write_reg(REG_RIGHT, r);
    write_reg(REG_BOTTOM, b);
    cfg_write <= 1'b0;
  endtask

  task automatic drain;
    seg_ch.valid <= 1'b0;
    while (pending_clips.size() != 0) @(posedge clk);
    repeat (3 + 36 * MAX_SUBDIVISIONS + 10) @(posedge clk);
  endtask

  // Valid stays high after an accept so that items can follow back to back.
  task automatic send_segment(coord_t sx, coord_t sy, coord_t ex, coord_t ey, logic known,
                              clip_result_t given);
    clip_result_t exp_res;
    while ($urandom_range(99) < send_idle_pct) begin
      seg_ch.valid <= 1'b0;
      @(posedge clk);
    end
    exp_res = clip_segment(sx, sy, ex, ey);
    if (known && exp_res != given) begin
      $error("table row disagrees with predictor for %0d,%0d-%0d,%0d", sx, sy, ex, ey);
      failures++;
    end
    seg_ch.valid <= 1'b1;
    seg_ch.start_x <= sx; seg_ch.start_y <= sy;
    seg_ch.end_x <= ex; seg_ch.end_y <= ey;
    do @(posedge clk); while (!seg_ch.ready);
    pending_clips.push_back(known ? given : exp_res);
  endtask

  function automatic coord_t rand_coord();
    case ($urandom_range(3))
      0: return coord_t'($urandom);
      1: return coord_t'($urandom_range(800) - 100);
      2: return coord_t'($urandom_range(1, 0) ? 32767 - $urandom_range(3) :
                         -32768 + $urandom_range(3));
      default: return coord_t'($urandom_range(2000) - 1000);
    endcase
  endfunction

  task automatic random_phase(int count);
    for (int i = 0; i < count; i++)
      send_segment(rand_coord(), rand_coord(), rand_coord(), rand_coord(), 1'b0,
                   '{1'b0, '0, '0, '0, '0});
  endtask

  // Result checker and receiver stall.
  always @(posedge clk) begin
    clip_result_t got, want;
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        got = '{res_ch.visible, res_ch.clipped_start_x, res_ch.clipped_start_y,
                res_ch.clipped_end_x, res_ch.clipped_end_y};
        if (pending_clips.size() == 0) begin
          $error("result with no segment outstanding");
          failures++;
        end else begin
          want = pending_clips.pop_front();
          if (got.visible !== want.visible) begin
            $error("visible: expected %0d, got %0d", want.visible, got.visible); failures++;
          end
          if (got.sx !== want.sx) begin
            $error("clipped_start_x: expected %0d, got %0d", want.sx, got.sx); failures++;
          end
          if (got.sy !== want.sy) begin
            $error("clipped_start_y: expected %0d, got %0d", want.sy, got.sy); failures++;
          end
          if (got.ex !== want.ex) begin
            $error("clipped_end_x: expected %0d, got %0d", want.ex, got.ex); failures++;
          end
          if (got.ey !== want.ey) begin
            $error("clipped_end_y: expected %0d, got %0d", want.ey, got.ey); failures++;
          end
        end
      end
      if (recv_hold_cycles > 0) begin
        recv_hold_cycles <= recv_hold_cycles - 1;
        res_ch.ready <= 1'b0;
      end else if (recv_hold) begin
        recv_hold <= 1'b0;
        recv_hold_cycles <= 1500;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    seg_row_t rows[$];
    clip_result_t rej;
    failures = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    recv_hold = 1'b0;
    recv_hold_cycles = 0;
    win_l = RESET_LEFT; win_t = RESET_TOP; win_r = RESET_RIGHT; win_b = RESET_BOTTOM;
    rst = 1'b1;
    cfg_write = 1'b0; cfg_index = REG_LEFT; cfg_data = '0;
    seg_ch.valid = 1'b0;
    seg_ch.start_x = '0; seg_ch.start_y = '0; seg_ch.end_x = '0; seg_ch.end_y = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    rej = '{1'b0, '0, '0, '0, '0};
    // Reset rectangle: inside, trivially rejected on each side, crossings, extremes.
    rows = '{
      '{10, 20, 600, 400, 1'b1, '{1'b1, 10, 20, 600, 400}},
      '{0, 0, 639, 479, 1'b1, '{1'b1, 0, 0, 639, 479}},
      '{-5, -5, -10, -20, 1'b1, rej},
      '{10, 500, 20, 600, 1'b1, rej},
      '{700, 10, 800, 20, 1'b1, rej},
      '{10, -1, 20, -2, 1'b1, rej},
      '{-32768, -32768, -32768, 32767, 1'b1, rej},
      '{32767, 32767, 32767, -32768, 1'b1, rej},
      '{-100, 240, 800, 240, 1'b1, '{1'b1, 0, 240, 639, 240}},
      '{320, -100, 320, 600, 1'b1, '{1'b1, 320, 0, 320, 479}},
      '{-32768, -32768, 32767, 32767, 1'b0, rej},
      '{32767, -32768, -32768, 32767, 1'b0, rej},
      '{100, 100, -50, 700, 1'b0, rej},
      '{-10, 470, 30, 500, 1'b0, rej},
      '{650, -5, 600, 20, 1'b0, rej},
      '{-1, 480, 640, -1, 1'b0, rej}
    };
    foreach (rows[i])
      send_segment(rows[i].sx, rows[i].sy, rows[i].ex, rows[i].ey, rows[i].known, rows[i].res);
    drain();

    // Inverted rectangle: shared-bit rejections.
    set_window(100, 100, -100, -100);
    send_segment(0, 0, 10, 10, 1'b0, rej);
    send_segment(-200, 0, 200, 0, 1'b0, rej);
    drain();

    send_idle_pct = 28; recv_idle_pct = 53;
    set_window(-32768, -32768, 32767, 32767);
    random_phase(150);
    drain();
    set_window(-300, -200, 300, 200);
    random_phase(300);
    // Long receiver stall while the sender keeps offering.
    recv_hold = 1'b1;
    random_phase(20);
    drain();

    send_idle_pct = 53; recv_idle_pct = 28;
    set_window(coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
               coord_t'($urandom));
    random_phase(200);
    drain();
    set_window(0, 0, 0, 0);
    random_phase(100);
    drain();

    send_idle_pct = 0; recv_idle_pct = 0;
    set_window(-1000, -800, 1200, 900);
    random_phase(300);
    drain();
    set_window(32767, 32767, -32768, -32768);
    random_phase(50);
    drain();
    set_window(RESET_LEFT, RESET_TOP, RESET_RIGHT, RESET_BOTTOM);
    random_phase(250);
    drain();

    if (failures == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/lsrc_pkg.sv
rtl/lsrc_if.sv
rtl/lsrc_datapath.sv
rtl/lsrc_controller.sv
rtl/line_segment_rect_clipper_unit.sv
test/tb_line_segment_rect_clipper_unit.sv
